@@ design/wmin2d_pkg.sv @@
// Package for the 2D sliding-window minimum block: widths, register codes, result type, helpers.
`default_nettype none

package wmin2d_pkg;

	// Field and register widths fixed by the block's interface.
	localparam int HEIGHT_W  = 30;
	localparam int SUM_W     = 54;
	localparam int CFG_W     = 13;
	localparam int WIN_REG_W = 5;
	localparam int CFG_IDX_W = 2;

	// Default sizes of the frame and the window.
	localparam int MAX_COLS_DEF = 4096;
	localparam int MAX_ROWS_DEF = 4096;
	localparam int MAX_WIN_DEF  = 16;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WIN_ROWS   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WIN_COLS   = 2'd3;

	// One result item as it waits in the output queue.
	typedef struct packed {
		logic [HEIGHT_W-1:0] window_min;
		logic [SUM_W-1:0]    sum_so_far;
		logic                frame_done;
	} result_t;

	// Number of pairwise compare levels in a min tree over n values.
	function automatic int tree_levels(input int n);
		return (n > 1) ? $clog2(n) : 1;
	endfunction

	// Latency of a min tree that registers after every second level and at its end.
	function automatic int tree_latency(input int n);
		return (tree_levels(n) + 1) / 2;
	endfunction

	// Register value as used: zero counts as one, values above hi count as hi.
	function automatic int clamp_reg(input logic [CFG_W-1:0] v, input int hi);
		int r;
		r = int'(v);
		if (r < 1) begin
			r = 1;
		end else if (r > hi) begin
			r = hi;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

@@ design/wmin2d_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module wmin2d_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                      wdata,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read; a read of the entry being written returns the old data.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

@@ design/wmin2d_min_tree.sv @@
// Pipelined minimum tree with a valid bit and a side-band vector carried alongside.
`default_nettype none

module wmin2d_min_tree
	import wmin2d_pkg::*;
#(
	parameter int N  = MAX_WIN_DEF,
	parameter int W  = HEIGHT_W,
	parameter int SB = 1
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire logic [W-1:0]  in_vals [N],
	input  wire logic [SB-1:0] in_sb,
	output logic               out_valid,
	output logic [W-1:0]       out_val,
	output logic [SB-1:0]      out_sb
);

	localparam int LV = tree_levels(N);

	logic [W-1:0]  lvl [LV+1][N];
	logic          vld [LV+1];
	logic [SB-1:0] sbv [LV+1];

	// Level zero is the raw input.
	for (genvar gi = 0; gi < N; gi++) begin : g_in
		assign lvl[0][gi] = in_vals[gi];
	end
	assign vld[0] = in_valid;
	assign sbv[0] = in_sb;

	// Each level halves the count; a register follows every second level and the last one.
	for (genvar gl = 1; gl <= LV; gl++) begin : g_lvl
		localparam int NQ = (N + (1 << (gl - 1)) - 1) >> (gl - 1);
		localparam int NP = (N + (1 << gl) - 1) >> gl;
		localparam bit REGD = (gl == LV) || ((gl % 2) == 0);

		for (genvar gi = 0; gi < N; gi++) begin : g_el
			if (gi < NP) begin : g_used
				logic [W-1:0] a;
				logic [W-1:0] b;
				logic [W-1:0] m;
				assign a = lvl[gl-1][2*gi];
				if (2 * gi + 1 < NQ) begin : g_pair
					assign b = lvl[gl-1][2*gi+1];
				end else begin : g_odd
					assign b = '1;
				end
				assign m = (b < a) ? b : a;
				if (REGD) begin : g_reg
					always_ff @(posedge clk) begin
						lvl[gl][gi] <= m;
					end
				end else begin : g_comb
					assign lvl[gl][gi] = m;
				end
			end else begin : g_unused
				assign lvl[gl][gi] = '1;
			end
		end

		if (REGD) begin : g_ctl_reg
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld[gl] <= 1'b0;
				end else begin
					vld[gl] <= vld[gl-1];
				end
			end
			always_ff @(posedge clk) begin
				sbv[gl] <= sbv[gl-1];
			end
		end else begin : g_ctl_comb
			assign vld[gl] = vld[gl-1];
			assign sbv[gl] = sbv[gl-1];
		end
	end

	assign out_valid = vld[LV];
	assign out_val   = lvl[LV][0];
	assign out_sb    = sbv[LV];

endmodule

`default_nettype wire

@@ design/window_min_2d_sum.sv @@
// Top level: streaming 2D window minimum over a raster image with a running sum of minima.
//
//  channel   direction  handshake             payload
//  in        sink       in_valid / in_ready   height
//  out       source     out_valid / out_ready window_min, sum_so_far, frame_done
//  cfg       sink       cfg_wr_en             cfg_index, cfg_data
//
// One pixel is taken per cycle while in_ready is high. Between input transfer and result lie
// the row min tree, the line store read, the column min tree and the output queue.
// The line store holds one word per column with the last MAX_WIN-1 row minima and
// is read and written back once per pixel; no clearing pass runs after reset.
// An output stall fills the output queue; in_ready drops only when the queue and
// the items in flight together reach its depth.
`default_nettype none

module window_min_2d_sum
	import wmin2d_pkg::*;
#(
	parameter int MAX_COLS = MAX_COLS_DEF,
	parameter int MAX_ROWS = MAX_ROWS_DEF,
	parameter int MAX_WIN  = MAX_WIN_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [HEIGHT_W-1:0]  height,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [HEIGHT_W-1:0]       window_min,
	output logic [SUM_W-1:0]          sum_so_far,
	output logic                      frame_done
);

	localparam int CW     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int RW     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CNW    = $clog2(MAX_COLS + 1);
	localparam int RNW    = $clog2(MAX_ROWS + 1);
	localparam int WNW    = $clog2(MAX_WIN + 1);
	localparam int LINE   = (MAX_WIN > 1) ? MAX_WIN - 1 : 1;
	localparam int WORD_W = LINE * HEIGHT_W;
	localparam int H_SB   = CW + 2 + LINE;
	localparam int FLIGHT = 2 * tree_latency(MAX_WIN) + 4;
	localparam int FD     = 1 << $clog2(FLIGHT);
	localparam int PW     = $clog2(FD);
	localparam int FCW    = $clog2(FD + 1);

	// Configuration, stored as the values in use.
	logic [RNW-1:0] rows_q;
	logic [CNW-1:0] cols_q;
	logic [WNW-1:0] wrows_q;
	logic [WNW-1:0] wcols_q;

	// Frame position and recent pixels of the current row.
	logic [CW-1:0]       col_q;
	logic [RW-1:0]       row_q;
	logic [HEIGHT_W-1:0] hp_q [LINE];

	logic accept;
	logic emit_in;
	logic last_in;
	logic col_wrap;

	logic [HEIGHT_W-1:0] h_vals [MAX_WIN];
	logic [LINE-1:0]     vmask_in;

	logic                hv;
	logic [HEIGHT_W-1:0] hrm;
	logic [H_SB-1:0]     hsb;
	logic [CW-1:0]       col_a;
	logic                emit_a;
	logic                last_a;
	logic [LINE-1:0]     vmask_a;

	// Line store access stage and its forwarding copy.
	logic                valid_s1;
	logic [CW-1:0]       col_s1;
	logic [HEIGHT_W-1:0] rm_s1;
	logic                emit_s1;
	logic                last_s1;
	logic [LINE-1:0]     vmask_s1;
	logic                valid_s2;
	logic [CW-1:0]       col_s2;
	logic [WORD_W-1:0]   word_s2;

	logic [WORD_W-1:0] rdata;
	logic [WORD_W-1:0] old_word;
	logic [WORD_W-1:0] new_word;

	logic [HEIGHT_W-1:0] v_vals [MAX_WIN];
	logic                vv;
	logic [HEIGHT_W-1:0] vmin;
	logic [1:0]          vsb;

	logic [SUM_W-1:0] sum_q;
	logic [SUM_W-1:0] sum_next;

	// Output queue.
	result_t        fifo_q [FD];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [FCW-1:0] fcnt_q;
	logic [FCW-1:0] inflight_q;
	logic           push;
	logic           pop;
	result_t        push_data;

	assign accept = in_valid && in_ready;

	// Window and frame position tests for the incoming pixel.
	assign emit_in  = (32'(row_q) + 32'd1 >= 32'(wrows_q)) &&
	                  (32'(col_q) + 32'd1 >= 32'(wcols_q));
	assign col_wrap = (32'(col_q) + 32'd1 == 32'(cols_q));
	assign last_in  = (32'(row_q) + 32'd1 == 32'(rows_q)) && col_wrap;

	// Row minimum candidates: earlier pixels of this row inside the window width.
	assign h_vals[0] = height;
	for (genvar gk = 1; gk < MAX_WIN; gk++) begin : g_hval
		assign h_vals[gk] = ((32'(gk) < 32'(wcols_q)) && (32'(gk) <= 32'(col_q))) ?
		                    hp_q[gk-1] : '1;
	end

	// Stored row minima that fall inside the window height.
	for (genvar gj = 0; gj < LINE; gj++) begin : g_vmask
		assign vmask_in[gj] = (32'(gj) + 32'd1 < 32'(wrows_q)) &&
		                      (32'(gj) + 32'd1 <= 32'(row_q));
	end

	// Configuration writes and frame position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q  <= RNW'(1);
			cols_q  <= CNW'(1);
			wrows_q <= WNW'(1);
			wcols_q <= WNW'(1);
			col_q   <= '0;
			row_q   <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_IMAGE_ROWS: rows_q  <= RNW'(clamp_reg(cfg_data, MAX_ROWS));
				REG_IMAGE_COLS: cols_q  <= CNW'(clamp_reg(cfg_data, MAX_COLS));
				REG_WIN_ROWS:   wrows_q <= WNW'(clamp_reg(CFG_W'(cfg_data[WIN_REG_W-1:0]),
				                                          MAX_WIN));
				REG_WIN_COLS:   wcols_q <= WNW'(clamp_reg(CFG_W'(cfg_data[WIN_REG_W-1:0]),
				                                          MAX_WIN));
				default: ;
			endcase
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (last_in) begin
				col_q <= '0;
				row_q <= '0;
			end else if (col_wrap) begin
				col_q <= '0;
				row_q <= row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// Shift line of the most recent pixels.
	always_ff @(posedge clk) begin
		if (accept) begin
			hp_q[0] <= height;
			for (int i = 1; i < LINE; i++) begin
				hp_q[i] <= hp_q[i-1];
			end
		end
	end

	// Row-wise minimum.
	wmin2d_min_tree #(
		.N  (MAX_WIN),
		.W  (HEIGHT_W),
		.SB (H_SB)
	) u_row_tree (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (accept),
		.in_vals   (h_vals),
		.in_sb     ({col_q, emit_in, last_in, vmask_in}),
		.out_valid (hv),
		.out_val   (hrm),
		.out_sb    (hsb)
	);

	assign {col_a, emit_a, last_a, vmask_a} = hsb;

	// Line store: one word per column, newest row minimum in the low bits.
	wmin2d_ram #(
		.WIDTH (WORD_W),
		.DEPTH (MAX_COLS)
	) u_line_store (
		.clk   (clk),
		.we    (valid_s1),
		.waddr (col_s1),
		.wdata (new_word),
		.raddr (col_a),
		.rdata (rdata)
	);

	// Read stage registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= hv;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		col_s1   <= col_a;
		rm_s1    <= hrm;
		emit_s1  <= emit_a;
		last_s1  <= last_a;
		vmask_s1 <= vmask_a;
		col_s2   <= col_s1;
		word_s2  <= new_word;
	end

	// The previous pixel wrote its column at the edge this read was issued; forward it.
	assign old_word = (valid_s2 && (col_s2 == col_s1)) ? word_s2 : rdata;
	assign new_word = WORD_W'({old_word, rm_s1});

	// Column minimum candidates.
	assign v_vals[0] = rm_s1;
	for (genvar gj = 1; gj < MAX_WIN; gj++) begin : g_vval
		assign v_vals[gj] = vmask_s1[gj-1] ? old_word[(gj-1)*HEIGHT_W +: HEIGHT_W] : '1;
	end

	// Column-wise minimum.
	wmin2d_min_tree #(
		.N  (MAX_WIN),
		.W  (HEIGHT_W),
		.SB (2)
	) u_col_tree (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s1),
		.in_vals   (v_vals),
		.in_sb     ({emit_s1, last_s1}),
		.out_valid (vv),
		.out_val   (vmin),
		.out_sb    (vsb)
	);

	// Running sum of the window minima of this frame.
	assign sum_next = sum_q + SUM_W'(vmin);
	assign push     = vv && vsb[1];
	assign pop      = out_valid && out_ready;

	always_comb begin
		push_data.window_min = vmin;
		push_data.sum_so_far = sum_next;
		push_data.frame_done = vsb[0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (cfg_wr_en) begin
			sum_q <= '0;
		end else if (vv) begin
			if (vsb[0]) begin
				sum_q <= '0;
			end else if (vsb[1]) begin
				sum_q <= sum_next;
			end
		end
	end

	// Output queue and the count of items still in the pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			fcnt_q     <= '0;
			inflight_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			fcnt_q     <= fcnt_q + FCW'(push) - FCW'(pop);
			inflight_q <= inflight_q + FCW'(accept) - FCW'(vv);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= push_data;
		end
	end

	assign in_ready   = (32'(fcnt_q) + 32'(inflight_q)) < FD;
	assign out_valid  = (fcnt_q != '0);
	assign window_min = fifo_q[rd_ptr_q].window_min;
	assign sum_so_far = fifo_q[rd_ptr_q].sum_so_far;
	assign frame_done = fifo_q[rd_ptr_q].frame_done;

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the streaming 2D window minimum with running sum of minima.

module tb_top;
	import wmin2d_pkg::*;

	localparam int LINE_DEPTH   = MAX_WIN_DEF - 1;
	localparam int ITEM_TARGET  = 1850;
	localparam int SETTLE_CYCLES = 12;
	localparam int LIMIT_CYCLES = 4_000_000;
	localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = '1;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [HEIGHT_W-1:0]  height = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [HEIGHT_W-1:0]  window_min;
	logic [SUM_W-1:0]     sum_so_far;
	logic                 frame_done;

	// Pixels waiting to be sent and window results waiting to arrive.
	logic [HEIGHT_W-1:0] pending_heights[$];
	result_t             expected_windows[$];

	// Shadow copy of the registers and the erosion state.
	logic [CFG_W-1:0]     cfg_image_rows, cfg_image_cols;
	logic [WIN_REG_W-1:0] cfg_win_rows, cfg_win_cols;
	int unsigned          cur_row, cur_col;
	logic [SUM_W-1:0]     frame_sum;
	logic [HEIGHT_W-1:0]  recent_px[LINE_DEPTH];
	logic [HEIGHT_W-1:0]  line_min[LINE_DEPTH][MAX_COLS_DEF];

	int      errors = 0;
	int      queued_items = 0;
	int      launched = 0;
	int      in_gap = 0;
	int      out_stall = 0;
	bit      steady_in = 0;
	bit      steady_out = 0;
	bit      drain_first = 0;
	result_t want;

	window_min_2d_sum u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.height     (height),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.window_min (window_min),
		.sum_so_far (sum_so_far),
		.frame_done (frame_done)
	);

	always #2 clk = ~clk;

	// A register value as the block uses it: zero counts as one, the top is clamped.
	function automatic int unsigned used_size(input int unsigned raw, input int unsigned hi);
		if (raw == 0) begin
			return 1;
		end
		return (raw > hi) ? hi : raw;
	endfunction

	// Idle length: mostly none or short, now and then long.
	function automatic int idle_len();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 60) begin
			return 0;
		end else if (pick < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	// Pixel values with weight on the extremes and on small values that tie often.
	function automatic logic [HEIGHT_W-1:0] draw_height();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return HEIGHT_MAX;
			2: return HEIGHT_W'($urandom_range(0, 15));
			3: return HEIGHT_MAX - HEIGHT_W'($urandom_range(0, 15));
			default: return HEIGHT_W'($urandom);
		endcase
	endfunction

	// Raw window size: mostly one that fits, sometimes too large, zero or beyond the maximum.
	function automatic logic [WIN_REG_W-1:0] pick_win(input int unsigned dim);
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 7) begin
			return WIN_REG_W'($urandom_range(1, (dim < MAX_WIN_DEF) ? dim : MAX_WIN_DEF));
		end else if (pick == 7) begin
			return WIN_REG_W'($urandom_range(1, MAX_WIN_DEF));
		end else if (pick == 8) begin
			return '0;
		end
		return WIN_REG_W'($urandom_range(MAX_WIN_DEF + 1, 31));
	endfunction

	task automatic clear_erosion_state();
		cfg_image_rows = 1;
		cfg_image_cols = 1;
		cfg_win_rows = 1;
		cfg_win_cols = 1;
		cur_row = 0;
		cur_col = 0;
		frame_sum = '0;
		for (int i = 0; i < LINE_DEPTH; i++) begin
			recent_px[i] = '0;
			for (int j = 0; j < MAX_COLS_DEF; j++) begin
				line_min[i][j] = '0;
			end
		end
	endtask

	// Row minimum over the last win_cols pixels, then column minimum over the
	// stored row minima of the last win_rows rows; one result per full window.
	task automatic predict_window(input logic [HEIGHT_W-1:0] h);
		int unsigned rows, cols, wr, wc, r, c;
		logic [HEIGHT_W-1:0] row_min, win_min, v;
		logic last_px;
		result_t res;
		rows = used_size(cfg_image_rows, MAX_ROWS_DEF);
		cols = used_size(cfg_image_cols, MAX_COLS_DEF);
		wr = used_size(cfg_win_rows, MAX_WIN_DEF);
		wc = used_size(cfg_win_cols, MAX_WIN_DEF);
		r = cur_row;
		c = cur_col;
		row_min = h;
		for (int unsigned k = 1; k < wc; k++) begin
			if (k <= c) begin
				v = recent_px[(c - k) % LINE_DEPTH];
				if (v < row_min) begin
					row_min = v;
				end
			end
		end
		recent_px[c % LINE_DEPTH] = h;
		win_min = row_min;
		for (int unsigned k = 1; k < wr; k++) begin
			if (k <= r) begin
				v = line_min[(r - k) % LINE_DEPTH][c];
				if (v < win_min) begin
					win_min = v;
				end
			end
		end
		line_min[r % LINE_DEPTH][c] = row_min;
		last_px = (r + 1 == rows) && (c + 1 == cols);
		if (r + 1 >= wr && c + 1 >= wc) begin
			frame_sum = frame_sum + win_min;
			res.window_min = win_min;
			res.sum_so_far = frame_sum;
			res.frame_done = last_px;
			expected_windows.push_back(res);
		end
		// Advance the raster position; the frame's last pixel restarts it.
		if (last_px) begin
			cur_row = 0;
			cur_col = 0;
			frame_sum = '0;
		end else if (c + 1 >= cols) begin
			cur_col = 0;
			cur_row = r + 1;
		end else begin
			cur_col = c + 1;
		end
	endtask

	// Sender: predicts on every input transfer, then offers the next pixel after its gap.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				predict_window(height);
			end
			if (!in_valid || in_ready) begin
				if (in_gap > 0) begin
					in_gap--;
					in_valid <= 1'b0;
				end else if (drain_first && expected_windows.size() != 0) begin
					in_valid <= 1'b0;
				end else if (pending_heights.size() != 0) begin
					drain_first = 0;
					in_valid <= 1'b1;
					height <= pending_heights.pop_front();
					launched++;
					// Every so often hold the next pixel until the output has caught up.
					if (launched % 350 == 0) begin
						drain_first = 1;
					end
					in_gap = steady_in ? 0 : idle_len();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: checks each output transfer against the oldest expected window.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_windows.size() == 0) begin
					$display("%0t unexpected result: expected none, got min %0h sum %0h done %0b",
						$time, window_min, sum_so_far, frame_done);
					errors++;
				end else begin
					want = expected_windows.pop_front();
					if (window_min !== want.window_min) begin
						$display("%0t window_min mismatch: expected %0h, got %0h",
							$time, want.window_min, window_min);
						errors++;
					end
					if (sum_so_far !== want.sum_so_far) begin
						$display("%0t sum_so_far mismatch: expected %0h, got %0h",
							$time, want.sum_so_far, sum_so_far);
						errors++;
					end
					if (frame_done !== want.frame_done) begin
						$display("%0t frame_done mismatch: expected %0b, got %0b",
							$time, want.frame_done, frame_done);
						errors++;
					end
				end
			end
			if (out_stall > 0) begin
				out_stall--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (!steady_out && $urandom_range(0, 4) == 0) begin
					out_stall = idle_len();
				end
			end
		end
	end

	task automatic queue_px(input logic [HEIGHT_W-1:0] h);
		pending_heights.push_back(h);
		queued_items++;
	endtask

	// Wait until every pixel is sent and every window result has come, then let
	// the pipeline settle since the last pixels may have caused no result.
	task automatic wait_idle();
		while (pending_heights.size() != 0 || in_valid || expected_windows.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			REG_IMAGE_ROWS: cfg_image_rows = val;
			REG_IMAGE_COLS: cfg_image_cols = val;
			REG_WIN_ROWS:   cfg_win_rows = val[WIN_REG_W-1:0];
			REG_WIN_COLS:   cfg_win_cols = val[WIN_REG_W-1:0];
			default: ;
		endcase
		// Any register write restarts the frame.
		cur_row = 0;
		cur_col = 0;
		frame_sum = '0;
	endtask

	// New frame and window geometry, written only while the block is idle.
	task automatic set_size(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] cols,
			input logic [CFG_W-1:0] wrows, input logic [CFG_W-1:0] wcols);
		wait_idle();
		steady_in = ($urandom_range(0, 3) == 0);
		steady_out = ($urandom_range(0, 3) == 0);
		write_reg(REG_IMAGE_ROWS, rows);
		write_reg(REG_IMAGE_COLS, cols);
		write_reg(REG_WIN_ROWS, wrows);
		write_reg(REG_WIN_COLS, wcols);
		@(negedge clk);
	endtask

	initial begin
		logic [HEIGHT_W-1:0] grid[12];
		int unsigned rows, cols, area, count;
		logic [CFG_W-1:0] raw_rows, raw_cols;
		clear_erosion_state();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset geometry: 1x1 frame and window, every pixel is a whole frame.
		queue_px('0);
		queue_px(HEIGHT_MAX);
		queue_px(30'h2AAA_AAAA);

		// Small frame with a 2x3 window over extreme and patterned values.
		set_size(3, 4, 2, 3);
		grid = '{HEIGHT_MAX, 30'h1555_5555, 30'h0, HEIGHT_MAX,
			30'h1, 30'h2AAA_AAAA, HEIGHT_MAX - 1, 30'h7,
			30'h2000_0000, 30'h5, HEIGHT_MAX, 30'h10};
		foreach (grid[i]) begin
			queue_px(grid[i]);
		end

		// Window taller than the frame: no result, but the frame still wraps.
		set_size(2, 2, 3, 1);
		repeat (4) queue_px(draw_height());

		// All registers zero behave as one.
		set_size(0, 0, 0, 0);
		queue_px(HEIGHT_MAX);
		queue_px('0);

		// Largest window over a full frame of the same size.
		set_size(16, 16, 16, 16);
		repeat (256) queue_px(draw_height());

		// Widest frame (clamped), window width at the maximum, high data bits set.
		set_size(13'h1FFF, 13'h1FFF, 13'h1FE0, 13'h1FF0);
		repeat (100) queue_px(draw_height());

		// Tallest frame with a full-height window on narrow rows.
		set_size(4096, 3, 16, 3);
		repeat (60) queue_px(draw_height());
		set_size(2, 4096, 2, 2);
		repeat (20) queue_px(draw_height());

		// Random geometries, mostly whole frames with random content.
		while (queued_items < ITEM_TARGET) begin
			cols = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
			rows = ($urandom_range(0, 4) == 0) ? $urandom_range(11, 24) : $urandom_range(1, 10);
			area = rows * cols;
			if ($urandom_range(0, 3) != 0) begin
				count = area * $urandom_range(1, 3);
			end else begin
				count = $urandom_range(1, 2 * area);
			end
			if (count > 500) begin
				count = area;
			end
			raw_rows = (rows == 1 && $urandom_range(0, 1) == 1) ? 13'd0 : CFG_W'(rows);
			raw_cols = (cols == 1 && $urandom_range(0, 1) == 1) ? 13'd0 : CFG_W'(cols);
			set_size(raw_rows, raw_cols,
				{8'($urandom_range(0, 255)), pick_win(rows)},
				{8'($urandom_range(0, 255)), pick_win(cols)});
			repeat (count) queue_px(draw_height());
		end

		wait_idle();
		if (errors == 0 && expected_windows.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	// Hard stop in case the handshakes hang.
	initial begin
		#(LIMIT_CYCLES * 4);
		$display("== FAIL ==");
		$finish;
	end

endmodule

@@ filelist.f @@
design/wmin2d_pkg.sv
design/wmin2d_ram.sv
design/wmin2d_min_tree.sv
design/window_min_2d_sum.sv
tb/sv/tb_top.sv
